// ----- hdl/bfpa_pkg.sv -----
// Shared types and constants for the BCD fixed-point ALU.
package bfpa_pkg;

  // Result and working width: 24 BCD digits
  localparam int unsigned Digits = 24;
  localparam int unsigned WordW  = 4 * Digits;
  localparam int unsigned GroupW = WordW / 2;

  typedef logic [WordW-1:0]  bcd_t;
  typedef logic [GroupW-1:0] group_t;

  // Operation codes
  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

endpackage

// ----- hdl/bfpa_bcd_addsub.sv -----
// Shared 24-digit BCD adder/subtractor with lookahead digit carries.
module bfpa_bcd_addsub (
  input  bfpa_pkg::bcd_t x,
  input  bfpa_pkg::bcd_t y,
  input  logic           sub,
  output bfpa_pkg::bcd_t sum,
  output logic           carry
);
  import bfpa_pkg::*;

  logic [4:0]        dsum [Digits];
  logic [Digits-1:0] gen;
  logic [Digits-1:0] prop;
  logic [Digits:0]   xv;
  logic [Digits:0]   yv;
  logic [Digits:0]   sv;
  logic [Digits:0]   cin;

  // Per-digit raw sums; subtract uses nines complement plus one
  always_comb begin
    for (int i = 0; i < Digits; i++) begin
      logic [3:0] yd;
      yd = sub ? (4'd9 - y[4*i +: 4]) : y[4*i +: 4];
      dsum[i] = {1'b0, x[4*i +: 4]} + {1'b0, yd};
      gen[i]  = (dsum[i] >= 5'd10);
      prop[i] = (dsum[i] == 5'd9);
    end
  end

  // Digit carries resolved by one binary add over generate/propagate
  assign xv  = {1'b0, gen | prop};
  assign yv  = {1'b0, gen};
  assign sv  = xv + yv + {{Digits{1'b0}}, sub};
  assign cin = sv ^ xv ^ yv;
  assign carry = sv[Digits];

  // Decimal correction per digit
  always_comb begin
    for (int i = 0; i < Digits; i++) begin
      logic [4:0] t;
      t = dsum[i] + {4'd0, cin[i]};
      sum[4*i +: 4] = (t >= 5'd10) ? 4'(t - 5'd10) : t[3:0];
    end
  end

endmodule

// ----- hdl/bcd_fixed_point_alu_unit.sv -----
// Top level of the BCD fixed-point ALU: sequencer around a shared BCD adder.
//
// Input channel (in_valid/in_ready) takes one word: operation, two signed
// operands of INT_DIGITS+FRAC_DIGITS BCD digits. Output channel
// (out_valid/out_ready) returns two words per input, high digit group first
// (group_index 0, then 1 with last set). The result is 24 BCD digits in
// sign-magnitude form with 2*FRAC_DIGITS fraction digits.
// One item at a time: in_ready is high only while the block is idle.
// All arithmetic goes through one 24-digit BCD add/subtract unit, one use
// per cycle. Steps from accept to the first output word: add/subtract takes
// one pass, and a second when |b| > |a|; multiply takes a shift step per
// multiplier digit, then one add of a per unit of that digit; divide makes
// trial subtractions per quotient digit until a borrow or the digit saturates
// at 9; a zero divisor goes straight to output. The two output words then
// leave when the receiver is ready. A stalled receiver holds the current
// word; no new input is taken until both words leave.
// Synchronous reset returns the sequencer to idle with no word pending.
module bcd_fixed_point_alu_unit #(
  parameter int unsigned INT_DIGITS  = 9,
  parameter int unsigned FRAC_DIGITS = 3
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           operation,
  input  logic                 a_negative,
  input  logic [47:0]          a_digits,
  input  logic                 b_negative,
  input  logic [47:0]          b_digits,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 result_negative,
  output bfpa_pkg::group_t     digit_group,
  output logic                 group_index,
  output logic                 last,
  output logic                 divide_by_zero
);
  import bfpa_pkg::*;

  localparam int unsigned OpDigits = INT_DIGITS + FRAC_DIGITS;
  localparam int unsigned PosW     = $clog2(OpDigits);
  localparam int unsigned FracSh   = 4 * FRAC_DIGITS;
  localparam int unsigned DivSh    = 4 * (OpDigits - 1);
  localparam logic [PosW-1:0] PosTop = PosW'(OpDigits - 1);

  // Sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ADD1 = 3'd1;
  localparam logic [2:0] S_ADD2 = 3'd2;
  localparam logic [2:0] S_MSH  = 3'd3;
  localparam logic [2:0] S_MADD = 3'd4;
  localparam logic [2:0] S_DTRY = 3'd5;
  localparam logic [2:0] S_OUT0 = 3'd6;
  localparam logic [2:0] S_OUT1 = 3'd7;

  logic [2:0]      state;
  bcd_t            a_reg;
  bcd_t            b_reg;
  bcd_t            acc;
  logic [3:0]      cnt;
  logic [PosW-1:0] pos;
  logic            a_neg;
  logic            b_neg;
  logic            res_neg;
  logic            dz;

  bcd_t            unit_x;
  bcd_t            unit_y;
  logic            unit_sub;
  bcd_t            unit_sum;
  logic            unit_carry;
  bcd_t            a_in;
  bcd_t            b_in;
  bcd_t            q_next;

  // Nibbles above 9 read as 9; digits above the operand width dropped
  function automatic bcd_t clamp_op(input logic [47:0] v);
    bcd_t r;
    r = '0;
    for (int i = 0; i < 12; i++) begin
      if (i < OpDigits) begin
        r[4*i +: 4] = (v[4*i +: 4] > 4'd9) ? 4'd9 : v[4*i +: 4];
      end
    end
    return r;
  endfunction

  assign a_in   = clamp_op(a_digits);
  assign b_in   = clamp_op(b_digits);
  assign q_next = {acc[WordW-5:0], cnt};

  // Operand routing into the shared unit
  always_comb begin
    unique case (state)
      S_ADD1: begin
        unit_x = a_reg; unit_y = b_reg; unit_sub = (a_neg != b_neg);
      end
      S_ADD2: begin
        unit_x = b_reg; unit_y = a_reg; unit_sub = 1'b1;
      end
      S_DTRY: begin
        unit_x = a_reg; unit_y = b_reg; unit_sub = 1'b1;
      end
      default: begin
        unit_x = acc; unit_y = a_reg; unit_sub = 1'b0;
      end
    endcase
  end

  bfpa_bcd_addsub u_addsub (
    .x     (unit_x),
    .y     (unit_y),
    .sub   (unit_sub),
    .sum   (unit_sum),
    .carry (unit_carry)
  );

  // Sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            a_neg <= a_negative;
            cnt   <= '0;
            pos   <= PosTop;
            acc   <= '0;
            unique case (op_t'(operation))
              OP_ADD, OP_SUB: begin
                a_reg <= a_in;
                b_reg <= b_in;
                b_neg <= b_negative ^ (op_t'(operation) == OP_SUB);
                dz    <= 1'b0;
                state <= S_ADD1;
              end
              OP_MUL: begin
                a_reg   <= a_in;
                b_reg   <= b_in;
                res_neg <= a_negative ^ b_negative;
                dz      <= 1'b0;
                state   <= S_MSH;
              end
              OP_DIV: begin
                dz <= (b_in == '0);
                if (b_in == '0) begin
                  res_neg <= 1'b0;
                  state   <= S_OUT0;
                end else begin
                  a_reg   <= a_in << FracSh;
                  b_reg   <= b_in << DivSh;
                  res_neg <= a_negative ^ b_negative;
                  state   <= S_DTRY;
                end
              end
            endcase
          end
        end
        // Signed add: magnitude add, or subtract with swap on borrow
        S_ADD1: begin
          if (!unit_sub || unit_carry) begin
            acc     <= unit_sum << FracSh;
            res_neg <= a_neg;
            state   <= S_OUT0;
          end else begin
            state <= S_ADD2;
          end
        end
        S_ADD2: begin
          acc     <= unit_sum << FracSh;
          res_neg <= b_neg;
          state   <= S_OUT0;
        end
        // Multiply: shift product, then add a once per unit of each multiplier digit
        S_MSH: begin
          acc   <= acc << 4;
          cnt   <= b_reg[4*OpDigits-1 -: 4];
          b_reg <= b_reg << 4;
          state <= S_MADD;
        end
        S_MADD: begin
          if (cnt == 4'd0) begin
            if (pos == '0) begin
              state <= S_OUT0;
            end else begin
              pos   <= pos - 1'b1;
              state <= S_MSH;
            end
          end else begin
            acc <= unit_sum;
            cnt <= cnt - 1'b1;
          end
        end
        // Divide: repeated trial subtraction, digit saturates at 9
        S_DTRY: begin
          if (unit_carry && cnt != 4'd9) begin
            a_reg <= unit_sum;
            cnt   <= cnt + 1'b1;
          end else begin
            cnt   <= '0;
            b_reg <= b_reg >> 4;
            if (pos == '0) begin
              acc   <= q_next << FracSh;
              state <= S_OUT0;
            end else begin
              acc <= q_next;
              pos <= pos - 1'b1;
            end
          end
        end
        S_OUT0: begin
          if (out_ready) begin
            state <= S_OUT1;
          end
        end
        S_OUT1: begin
          if (out_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Output word
  assign in_ready        = (state == S_IDLE);
  assign out_valid       = (state == S_OUT0) || (state == S_OUT1);
  assign group_index     = (state == S_OUT1);
  assign last            = group_index;
  assign digit_group     = group_index ? acc[GroupW-1:0] : acc[WordW-1:GroupW];
  assign result_negative = res_neg && (acc != '0);
  assign divide_by_zero  = dz;

  // Checks
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input taken while output pending");

  a_digit_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_DTRY || state == S_MADD) |-> (cnt <= 4'd9))
    else $error("digit counter out of range");

  a_second_word: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !group_index) |=> (out_valid && group_index))
    else $error("second word missing");

  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && divide_by_zero) |-> (digit_group == '0 && !result_negative))
    else $error("divide by zero word not clear");

endmodule

// ----- dv/tb_bcd_fixed_point_alu_unit.sv -----
// Testbench for the BCD fixed-point ALU: directed and random words checked against a predictor.
module tb_bcd_fixed_point_alu_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import bfpa_pkg::*;

  typedef struct packed {
    logic        neg;
    logic [47:0] grp;
    logic        idx;
    logic        lst;
    logic        dz;
  } alu_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  operation = '0;
  logic        a_negative = 1'b0;
  logic [47:0] a_digits = '0;
  logic        b_negative = 1'b0;
  logic [47:0] b_digits = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        result_negative;
  group_t      digit_group;
  logic        group_index;
  logic        last;
  logic        divide_by_zero;

  alu_word_t   expected_words[$];
  int          error_count = 0;
  bit          idle_enable = 1'b1;

  bcd_fixed_point_alu_unit i_dut (.*);

  initial forever #5 clk = ~clk;

  // Limit on run time
  initial begin
    #50ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic longint unsigned bcd_to_int(logic [47:0] bits);
    longint unsigned v;
    longint unsigned nib;
    v = 0;
    for (int i = 11; i >= 0; i--) begin
      nib = 64'(bits[4*i +: 4]);
      if (nib > 9) nib = 9;
      v = v * 10 + nib;
    end
    return v;
  endfunction

  function automatic logic [47:0] int_to_bcd(longint unsigned v);
    logic [47:0] r;
    r = '0;
    for (int i = 0; i < 12; i++) begin
      r[4*i +: 4] = 4'(v % 10);
      v = v / 10;
    end
    return r;
  endfunction

  // Compute the two expected output words of one operation
  task automatic predict_result(op_t op, logic an, logic [47:0] ad, logic bn,
                                logic [47:0] bd);
    longint unsigned a, b, hi, lo, m, a1, a0, b1, b0, mid, low, rem, q, w, d;
    longint sa, sb, s;
    logic neg, dz;
    alu_word_t wd;
    a = bcd_to_int(ad);
    b = bcd_to_int(bd);
    hi = 0; lo = 0; neg = 1'b0; dz = 1'b0;
    case (op)
      OP_ADD, OP_SUB: begin
        sa = an ? -longint'(a) : longint'(a);
        sb = bn ? -longint'(b) : longint'(b);
        s = (op == OP_ADD) ? sa + sb : sa - sb;
        neg = s < 0;
        m = (neg ? longint'(-s) : s) * 1000;
        hi = m / 64'd1000000000000;
        lo = m % 64'd1000000000000;
      end
      OP_MUL: begin
        a1 = a / 1000000; a0 = a % 1000000;
        b1 = b / 1000000; b0 = b % 1000000;
        mid = a1 * b0 + a0 * b1;
        low = a0 * b0 + (mid % 1000000) * 1000000;
        hi = a1 * b1 + mid / 1000000 + low / 64'd1000000000000;
        lo = low % 64'd1000000000000;
        neg = an != bn;
      end
      default: begin
        if (b == 0) dz = 1'b1;
        else begin
          rem = a * 1000;
          q = 0;
          w = 64'd100000000000;
          for (int p = 11; p >= 0; p--) begin
            d = 0;
            if (b <= rem / w) begin
              d = rem / (w * b);
              if (d > 9) d = 9;
              rem -= d * w * b;
            end
            q += d * w;
            w = w / 10;
          end
          m = q * 1000;
          hi = m / 64'd1000000000000;
          lo = m % 64'd1000000000000;
          neg = an != bn;
        end
      end
    endcase
    if (hi == 0 && lo == 0) neg = 1'b0;
    for (int k = 0; k < 2; k++) begin
      wd.neg = neg;
      wd.grp = int_to_bcd(k == 0 ? hi : lo);
      wd.idx = k[0];
      wd.lst = k[0];
      wd.dz  = dz;
      expected_words.push_back(wd);
    end
  endtask

  // Send one word, with random idle cycles before it while idle_enable is set
  task automatic send_word(op_t op, logic an, logic [47:0] ad, logic bn, logic [47:0] bd);
    while (idle_enable && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    predict_result(op, an, ad, bn, bd);
    operation  <= op;
    a_negative <= an;
    a_digits   <= ad;
    b_negative <= bn;
    b_digits   <= bd;
    in_valid   <= 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  // Random receiver stalls while idle_enable is set
  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= !idle_enable || ($urandom_range(99) >= 15);
  end

  // Compare each output word with the oldest expectation
  always @(posedge clk) begin
    alu_word_t exp_w;
    if (!rst && out_valid && out_ready) begin
      if (expected_words.size() == 0) begin
        $error("output word with none expected");
        error_count++;
      end else begin
        exp_w = expected_words.pop_front();
        if (result_negative !== exp_w.neg) begin
          $error("result_negative exp %0b got %0b", exp_w.neg, result_negative);
          error_count++;
        end
        if (digit_group !== exp_w.grp) begin
          $error("digit_group exp %h got %h", exp_w.grp, digit_group);
          error_count++;
        end
        if (group_index !== exp_w.idx) begin
          $error("group_index exp %0b got %0b", exp_w.idx, group_index);
          error_count++;
        end
        if (last !== exp_w.lst) begin
          $error("last exp %0b got %0b", exp_w.lst, last);
          error_count++;
        end
        if (divide_by_zero !== exp_w.dz) begin
          $error("divide_by_zero exp %0b got %0b", exp_w.dz, divide_by_zero);
          error_count++;
        end
      end
    end
  end

  function automatic logic [47:0] rand_digits(bit allow_bad);
    logic [47:0] r;
    int n;
    r = '0;
    n = $urandom_range(12, 1);
    for (int i = 0; i < n; i++)
      r[4*i +: 4] = allow_bad ? 4'($urandom_range(15)) : 4'($urandom_range(9));
    return r;
  endfunction

  // Drop valid after the last word and wait for all results
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
  endtask

  // Extremes, every operation, zero results, zero divisor, bad nibbles
  task automatic test_directed();
    logic [47:0] nines;
    nines = 48'h999999999999;
    send_word(OP_ADD, 1'b0, nines, 1'b0, nines);
    send_word(OP_ADD, 1'b1, nines, 1'b1, nines);
    send_word(OP_ADD, 1'b1, 48'h123, 1'b0, 48'h123);
    send_word(OP_SUB, 1'b0, 48'h5, 1'b0, nines);
    send_word(OP_SUB, 1'b1, nines, 1'b0, nines);
    send_word(OP_SUB, 1'b1, 48'h42, 1'b1, 48'h42);
    send_word(OP_MUL, 1'b0, nines, 1'b0, nines);
    send_word(OP_MUL, 1'b1, nines, 1'b0, nines);
    send_word(OP_MUL, 1'b1, 48'h0, 1'b0, nines);
    send_word(OP_MUL, 1'b0, 48'hFFFFFFFFFFFF, 1'b1, 48'hFFFFFFFFFFFF);
    send_word(OP_DIV, 1'b1, nines, 1'b0, 48'h0);
    send_word(OP_DIV, 1'b0, 48'h0, 1'b1, 48'h0);
    send_word(OP_DIV, 1'b0, nines, 1'b0, 48'h1);
    send_word(OP_DIV, 1'b1, nines, 1'b1, nines);
    send_word(OP_DIV, 1'b0, 48'h1, 1'b1, nines);
    send_word(OP_DIV, 1'b1, 48'h0, 1'b0, 48'h7);
    send_word(OP_DIV, 1'b0, 48'hABCDEF012345, 1'b0, 48'h3);
    send_word(OP_ADD, 1'b0, 48'hFFFFFFFFFFFF, 1'b1, 48'hAAAAAAAAAAAA);
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) begin
      send_word(op_t'($urandom_range(3)), 1'($urandom_range(1)),
                rand_digits($urandom_range(9) == 0), 1'($urandom_range(1)),
                ($urandom_range(19) == 0) ? 48'h0 : rand_digits($urandom_range(9) == 0));
      // At the halfway point the sender holds off until the block is fully drained
      if (i == count / 2) wait_drained();
    end
  endtask

  task automatic test_no_idle(int count);
    idle_enable = 1'b0;
    test_random(count);
    wait_drained();
    idle_enable = 1'b1;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(600);
    test_no_idle(200);
    test_random(200);
    wait_drained();
    repeat (300) @(posedge clk);
    if (error_count == 0 && expected_words.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
